/* src/aies_pkg.sv */
package aies_pkg;

    // Default sizing of the entry table
    localparam int MAX_ENTRIES_DEF = 256;
    localparam int NAME_CHARS_DEF  = 8;

    // Fixed field widths
    localparam int COUNT_W  = 9;
    localparam int SLOT_W   = 8;
    localparam int ID_W     = 32;
    localparam int ID_BYTES = 4;
    localparam int NAME_W   = 64;
    localparam int MODE_W   = 3;
    localparam int VER_W    = 15;
    localparam int FLAG_W   = 2;
    localparam int SIZE_W   = 32;
    localparam int OFFS_W   = 32;

    // Item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Version modes
    localparam logic [MODE_W-1:0] MODE_EXACT   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LATEST  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_OLD     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DELETED = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LIVE    = 3'd4;

    // Flag bit positions
    localparam int FLAG_DEL_BIT = 0;
    localparam int FLAG_SUP_BIT = 1;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    // Map ASCII upper case letters to lower case
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5a)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

/* src/archive_index_entry_search.sv */
// Archive index entry search.
// Input channel (in_valid/in_ready) takes write items and query items.
// A write item stores one entry into the table in the cycle it is
// accepted and gives no result; the next item may follow in the next cycle.
// A query item scans slots 0 to entry_count-1 (at most the table depth),
// one table read per cycle, and gives one result on the output channel
// (out_valid/out_ready): the first matching slot with its size and offset,
// or all zeros with found low.
// A query reads one slot at a time through the single read port of the entry
// RAM up to the hit or the scan end, then compares the last entry read and
// settles the result, then loads the output register. The input opens as
// the output loads; no new item is taken while a query is in flight.
// The user writes entry_count through cfg_we/cfg_wdata while the block is
// idle; the block itself does not enforce it. Reset clears the controller,
// count and output valid; the entry RAM holds no defined content until written.
// A stalled receiver holds the result in the output register; a query that
// finishes meanwhile waits in its finish state and no new item is taken.
module archive_index_entry_search #(
    parameter int MAX_ENTRIES = aies_pkg::MAX_ENTRIES_DEF,
    parameter int NAME_CHARS  = aies_pkg::NAME_CHARS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [aies_pkg::COUNT_W-1:0]     cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             kind,
    input  logic [aies_pkg::SLOT_W-1:0]      slot,
    input  logic [aies_pkg::ID_W-1:0]        format_id,
    input  logic [aies_pkg::NAME_W-1:0]      name_bytes,
    input  logic                             name_given,
    input  logic [aies_pkg::MODE_W-1:0]      version_mode,
    input  logic [aies_pkg::VER_W-1:0]       version_number,
    input  logic                             deleted_flag,
    input  logic                             superseded_flag,
    input  logic [aies_pkg::SIZE_W-1:0]      entry_size,
    input  logic [aies_pkg::OFFS_W-1:0]      entry_offset,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             found,
    output logic [aies_pkg::SLOT_W-1:0]      match_slot,
    output logic [aies_pkg::SIZE_W-1:0]      match_size,
    output logic [aies_pkg::OFFS_W-1:0]      match_offset
);

    localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int NW     = 8 * NAME_CHARS;
    localparam int CNT_W  = aies_pkg::COUNT_W;

    // Entry word layout
    localparam int OFFS_LO = 0;
    localparam int SIZE_LO = OFFS_LO + aies_pkg::OFFS_W;
    localparam int FLAG_LO = SIZE_LO + aies_pkg::SIZE_W;
    localparam int VER_LO  = FLAG_LO + aies_pkg::FLAG_W;
    localparam int NAME_LO = VER_LO + aies_pkg::VER_W;
    localparam int ID_LO   = NAME_LO + NW;
    localparam int WORD_W  = ID_LO + aies_pkg::ID_W;

    localparam logic [16:0] DEPTH_CMP = 17'(MAX_ENTRIES);

    aies_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] lim_reg, lim_next;
    logic [CNT_W-1:0] iss_reg, iss_next;
    logic             pend_reg, pend_next;
    logic [CNT_W-1:0] pend_slot_reg, pend_slot_next;

    logic [aies_pkg::ID_W-1:0]   q_id_reg;
    logic [NW-1:0]               q_name_reg;
    logic                        q_use_name_reg;
    logic [aies_pkg::MODE_W-1:0] q_mode_reg;
    logic [aies_pkg::VER_W-1:0]  q_ver_reg;

    logic                          res_found_reg, res_found_next;
    logic [aies_pkg::SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic [aies_pkg::SIZE_W-1:0]   res_size_reg, res_size_next;
    logic [aies_pkg::OFFS_W-1:0]   res_offset_reg, res_offset_next;

    logic                          out_valid_reg, out_valid_next;
    logic                          found_reg;
    logic [aies_pkg::SLOT_W-1:0]   match_slot_reg;
    logic [aies_pkg::SIZE_W-1:0]   match_size_reg;
    logic [aies_pkg::OFFS_W-1:0]   match_offset_reg;

    logic              in_acc;
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [WORD_W-1:0] wr_data;
    logic [WORD_W-1:0] rd_data;
    logic [CNT_W-1:0]  lim_in;
    logic              out_free;
    logic              load_out;

    logic [aies_pkg::ID_W-1:0]   e_id;
    logic [NW-1:0]               e_name;
    logic [aies_pkg::VER_W-1:0]  e_ver;
    logic [aies_pkg::FLAG_W-1:0] e_flags;
    logic [aies_pkg::SIZE_W-1:0] e_size;
    logic [aies_pkg::OFFS_W-1:0] e_offset;
    logic                        name_ok;
    logic                        ver_ok;
    logic                        id_ok;
    logic                        hit;

    assign in_ready = (state_reg == aies_pkg::ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign load_out = (state_reg == aies_pkg::ST_FINISH) && out_free;

    // Clamp the scan length to the table depth
    assign lim_in = ({8'd0, count_reg} > DEPTH_CMP) ? CNT_W'(MAX_ENTRIES) : count_reg;

    // Entry RAM write port
    assign wr_en = in_acc && (kind == aies_pkg::KIND_WRITE) &&
                   ({9'd0, slot} < DEPTH_CMP);
    assign wr_data = {format_id, name_bytes[NW-1:0], version_number,
                      superseded_flag, deleted_flag, entry_size, entry_offset};

    // Entry RAM read port: one slot per scan cycle
    assign rd_en   = (state_reg == aies_pkg::ST_SCAN) && (iss_reg < lim_reg);
    assign rd_addr = ADDR_W'(iss_reg);

    aies_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_ENTRIES)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(slot)),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Unpack the entry read back
    assign e_offset = rd_data[OFFS_LO +: aies_pkg::OFFS_W];
    assign e_size   = rd_data[SIZE_LO +: aies_pkg::SIZE_W];
    assign e_flags  = rd_data[FLAG_LO +: aies_pkg::FLAG_W];
    assign e_ver    = rd_data[VER_LO +: aies_pkg::VER_W];
    assign e_name   = rd_data[NAME_LO +: NW];
    assign e_id     = rd_data[ID_LO +: aies_pkg::ID_W];

    // Case-blind name compare, ending at the first shared zero byte
    always_comb
    begin
        logic       stop;
        logic [7:0] ca;
        logic [7:0] cb;
        name_ok = 1'b1;
        stop    = 1'b0;
        for (int k = 0; k < NAME_CHARS; k++)
        begin
            ca = aies_pkg::fold_case(q_name_reg[8*k +: 8]);
            cb = aies_pkg::fold_case(e_name[8*k +: 8]);
            if (!stop)
            begin
                if (ca != cb)
                begin
                    name_ok = 1'b0;
                    stop    = 1'b1;
                end
                else if (ca == 8'h00)
                begin
                    stop = 1'b1;
                end
            end
        end
        if (!q_use_name_reg)
        begin
            name_ok = 1'b1;
        end
    end

    // Version mode check
    always_comb
    begin
        logic del;
        logic sup;
        del = e_flags[aies_pkg::FLAG_DEL_BIT];
        sup = e_flags[aies_pkg::FLAG_SUP_BIT];
        case (q_mode_reg)
            aies_pkg::MODE_DELETED: ver_ok = del;
            aies_pkg::MODE_EXACT:   ver_ok = !del && (e_ver == q_ver_reg);
            aies_pkg::MODE_LATEST:  ver_ok = !del && !sup;
            aies_pkg::MODE_OLD:     ver_ok = !del && sup;
            default:                ver_ok = !del;
        endcase
    end

    // Id compare, zero query bytes match anything
    always_comb
    begin
        id_ok = 1'b1;
        for (int k = 0; k < aies_pkg::ID_BYTES; k++)
        begin
            if (q_id_reg[8*k +: 8] != 8'h00 && q_id_reg[8*k +: 8] != e_id[8*k +: 8])
            begin
                id_ok = 1'b0;
            end
        end
    end

    assign hit = pend_reg && name_ok && ver_ok && id_ok;

    // Scan controller
    always_comb
    begin
        state_next      = state_reg;
        lim_next        = lim_reg;
        iss_next        = iss_reg;
        pend_next       = 1'b0;
        pend_slot_next  = pend_slot_reg;
        res_found_next  = res_found_reg;
        res_slot_next   = res_slot_reg;
        res_size_next   = res_size_reg;
        res_offset_next = res_offset_reg;
        unique case (state_reg)
            aies_pkg::ST_IDLE:
            begin
                if (in_acc && kind == aies_pkg::KIND_QUERY)
                begin
                    lim_next   = lim_in;
                    iss_next   = '0;
                    state_next = aies_pkg::ST_SCAN;
                end
            end
            aies_pkg::ST_SCAN:
            begin
                if (rd_en)
                begin
                    iss_next       = iss_reg + 1'b1;
                    pend_next      = 1'b1;
                    pend_slot_next = iss_reg;
                end
                if (hit)
                begin
                    res_found_next  = 1'b1;
                    res_slot_next   = pend_slot_reg[aies_pkg::SLOT_W-1:0];
                    res_size_next   = e_size;
                    res_offset_next = e_offset;
                    pend_next       = 1'b0;
                    state_next      = aies_pkg::ST_FINISH;
                end
                else if (!rd_en && !pend_reg || !rd_en && pend_reg)
                begin
                    res_found_next  = 1'b0;
                    res_slot_next   = '0;
                    res_size_next   = '0;
                    res_offset_next = '0;
                    state_next      = aies_pkg::ST_FINISH;
                end
            end
            aies_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = aies_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = aies_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register: drop on take, load from finish
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= aies_pkg::ST_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        lim_reg        <= lim_next;
        iss_reg        <= iss_next;
        pend_slot_reg  <= pend_slot_next;
        res_found_reg  <= res_found_next;
        res_slot_reg   <= res_slot_next;
        res_size_reg   <= res_size_next;
        res_offset_reg <= res_offset_next;
        if (in_acc && kind == aies_pkg::KIND_QUERY)
        begin
            q_id_reg       <= format_id;
            q_name_reg     <= name_bytes[NW-1:0];
            q_use_name_reg <= name_given;
            q_mode_reg     <= version_mode;
            q_ver_reg      <= version_number;
        end
        if (load_out)
        begin
            found_reg        <= res_found_reg;
            match_slot_reg   <= res_slot_reg;
            match_size_reg   <= res_size_reg;
            match_offset_reg <= res_offset_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign match_slot   = match_slot_reg;
    assign match_size   = match_size_reg;
    assign match_offset = match_offset_reg;

    // A pending read always belongs to a slot inside the scan range
    a_pend_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (pend_slot_reg < lim_reg) && (state_reg == aies_pkg::ST_SCAN))
        else $error("pending read outside scan range");

    // No table write while a query is in flight
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == aies_pkg::ST_IDLE))
        else $error("table write during query");

    // A miss reports all-zero fields
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |->
            (match_slot == '0) && (match_size == '0) && (match_offset == '0))
        else $error("miss result carries nonzero fields");

    // Leaving finish always presents a result next cycle
    a_finish_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid && (state_reg == aies_pkg::ST_IDLE))
        else $error("finished query not delivered");

    // Scan issue pointer never runs past its limit
    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == aies_pkg::ST_SCAN) |-> (iss_reg <= lim_reg))
        else $error("scan pointer past limit");

endmodule

/* src/aies_ram.sv */
module aies_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* tb/sv/archive_index_entry_search_test.sv */
module archive_index_entry_search_test;
    timeunit 1ns;
    timeprecision 1ps;

    import aies_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
    localparam int NAME_POOL_N = 6;
    localparam int ID_POOL_N   = 4;
    localparam int PHASES      = 12;
    localparam int HALF_PHASE  = 80;
    localparam int SCAN_TAIL   = 300;

    typedef struct packed {
        logic                kind;
        logic [SLOT_W-1:0]   slot;
        logic [ID_W-1:0]     id;
        logic [NAME_W-1:0]   name;
        logic                name_given;
        logic [MODE_W-1:0]   mode;
        logic [VER_W-1:0]    ver;
        logic                del;
        logic                sup;
        logic [SIZE_W-1:0]   size;
        logic [OFFS_W-1:0]   offs;
    } entry_item_t;

    typedef struct packed {
        logic                found;
        logic [SLOT_W-1:0]   slot;
        logic [SIZE_W-1:0]   size;
        logic [OFFS_W-1:0]   offs;
    } match_t;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                cfg_we     = 1'b0;
    logic [COUNT_W-1:0]  cfg_wdata  = '0;
    logic                in_valid   = 1'b0;
    logic                in_ready;
    entry_item_t         drive_item = '0;
    entry_item_t         next_item;
    logic                out_valid;
    logic                out_ready  = 1'b0;
    logic                found;
    logic [SLOT_W-1:0]   match_slot;
    logic [SIZE_W-1:0]   match_size;
    logic [OFFS_W-1:0]   match_offset;

    // Model of the entry table and the scan count
    logic [ID_W-1:0]     index_id    [MAX_ENTRIES_DEF];
    logic [NAME_W-1:0]   index_name  [MAX_ENTRIES_DEF];
    logic [VER_W-1:0]    index_ver   [MAX_ENTRIES_DEF];
    logic [FLAG_W-1:0]   index_flags [MAX_ENTRIES_DEF];
    logic [SIZE_W-1:0]   index_size  [MAX_ENTRIES_DEF];
    logic [OFFS_W-1:0]   index_offs  [MAX_ENTRIES_DEF];
    logic [COUNT_W-1:0]  scan_count = '0;

    // Stimulus bookkeeping: which slots hold data, and value pools for hits
    bit                  slot_filled [MAX_ENTRIES_DEF];
    int                  filled_prefix = 0;
    logic [NAME_W-1:0]   name_pool [NAME_POOL_N];
    logic [ID_W-1:0]     id_pool [ID_POOL_N];

    entry_item_t         item_backlog [$];
    match_t              pending_matches [$];
    match_t              want;
    match_t              seen;
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;
    int                  mismatch_count = 0;

    archive_index_entry_search u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (drive_item.kind),
        .slot            (drive_item.slot),
        .format_id       (drive_item.id),
        .name_bytes      (drive_item.name),
        .name_given      (drive_item.name_given),
        .version_mode    (drive_item.mode),
        .version_number  (drive_item.ver),
        .deleted_flag    (drive_item.del),
        .superseded_flag (drive_item.sup),
        .entry_size      (drive_item.size),
        .entry_offset    (drive_item.offs),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .found           (found),
        .match_slot      (match_slot),
        .match_size      (match_size),
        .match_offset    (match_offset)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Fold ASCII capitals only; every other byte stays as it is
    function automatic logic [7:0] lower_char(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5a)
        begin
            return c + 8'h20;
        end
        return c;
    endfunction

    // Names agree up to the first position where both hold a zero byte
    function automatic logic names_match(input logic [NAME_W-1:0] a,
                                         input logic [NAME_W-1:0] b);
        logic [7:0] ca;
        logic [7:0] cb;
        for (int k = 0; k < NAME_CHARS_DEF; k++)
        begin
            ca = lower_char(a[8*k +: 8]);
            cb = lower_char(b[8*k +: 8]);
            if (ca != cb)
            begin
                return 1'b0;
            end
            if (ca == 8'h00)
            begin
                return 1'b1;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic entry_hit(input int s, input entry_item_t q);
        logic is_del;
        logic is_sup;
        is_del = index_flags[s][FLAG_DEL_BIT];
        is_sup = index_flags[s][FLAG_SUP_BIT];
        if (q.name_given && !names_match(q.name, index_name[s]))
        begin
            return 1'b0;
        end
        if (q.mode == MODE_DELETED)
        begin
            if (!is_del)
            begin
                return 1'b0;
            end
        end
        else
        begin
            // unused mode codes behave as any live entry
            if (is_del)
            begin
                return 1'b0;
            end
            if (q.mode == MODE_LATEST && is_sup)
            begin
                return 1'b0;
            end
            if (q.mode == MODE_OLD && !is_sup)
            begin
                return 1'b0;
            end
            if (q.mode == MODE_EXACT && index_ver[s] != q.ver)
            begin
                return 1'b0;
            end
        end
        // zero id bytes in the query are wildcards
        for (int b = 0; b < ID_BYTES; b++)
        begin
            if (q.id[8*b +: 8] != 8'h00 && q.id[8*b +: 8] != index_id[s][8*b +: 8])
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // First hit among the scanned slots, all zeros when none
    function automatic match_t search_index(input entry_item_t q);
        match_t r;
        int     limit;
        r = '0;
        limit = (scan_count > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : int'(scan_count);
        for (int s = 0; s < limit && !r.found; s++)
        begin
            if (entry_hit(s, q))
            begin
                r.found = 1'b1;
                r.slot  = SLOT_W'(s);
                r.size  = index_size[s];
                r.offs  = index_offs[s];
            end
        end
        return r;
    endfunction

    function automatic logic [NAME_W-1:0] pack_name(input string s);
        logic [NAME_W-1:0] r;
        r = '0;
        for (int k = 0; k < s.len() && k < NAME_CHARS_DEF; k++)
        begin
            r[8*k +: 8] = s[k];
        end
        return r;
    endfunction

    function automatic logic [VER_W-1:0] pick_version();
        case ($urandom_range(0, 9))
            0:       return VER_W'($urandom());
            1:       return '1;
            default: return VER_W'($urandom_range(0, 3));
        endcase
    endfunction

    // Pool name with random letter case and junk past the terminator, or noise
    function automatic logic [NAME_W-1:0] pool_name();
        logic [NAME_W-1:0] r;
        logic [7:0]        c;
        logic              past_end;
        if ($urandom_range(0, 4) == 0)
        begin
            return {$urandom(), $urandom()};
        end
        r = name_pool[$urandom_range(0, NAME_POOL_N - 1)];
        past_end = 1'b0;
        for (int k = 0; k < NAME_CHARS_DEF; k++)
        begin
            c = r[8*k +: 8];
            if (past_end)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    r[8*k +: 8] = 8'($urandom());
                end
            end
            else if (c == 8'h00)
            begin
                past_end = 1'b1;
            end
            else if (((c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a))
                     && $urandom_range(0, 1) == 1)
            begin
                r[8*k +: 8] = c ^ 8'h20;
            end
        end
        return r;
    endfunction

    function automatic void put_entry(input logic [SLOT_W-1:0] s,
                                      input logic [ID_W-1:0]   id,
                                      input logic [NAME_W-1:0] nm,
                                      input logic [VER_W-1:0]  v,
                                      input logic              del,
                                      input logic              sup,
                                      input logic [SIZE_W-1:0] sz,
                                      input logic [OFFS_W-1:0] off);
        entry_item_t it;
        it.kind       = KIND_WRITE;
        it.slot       = s;
        it.id         = id;
        it.name       = nm;
        it.name_given = 1'($urandom());
        it.mode       = MODE_W'($urandom());
        it.ver        = v;
        it.del        = del;
        it.sup        = sup;
        it.size       = sz;
        it.offs       = off;
        item_backlog.push_back(it);
        slot_filled[s] = 1'b1;
        while (filled_prefix < MAX_ENTRIES_DEF && slot_filled[filled_prefix])
        begin
            filled_prefix++;
        end
    endfunction

    function automatic void put_query(input logic [ID_W-1:0]   id,
                                      input logic [NAME_W-1:0] nm,
                                      input logic              given,
                                      input logic [MODE_W-1:0] mode,
                                      input logic [VER_W-1:0]  v);
        entry_item_t it;
        it.kind       = KIND_QUERY;
        it.slot       = SLOT_W'($urandom());
        it.id         = id;
        it.name       = nm;
        it.name_given = given;
        it.mode       = mode;
        it.ver        = v;
        it.del        = 1'($urandom());
        it.sup        = 1'($urandom());
        it.size       = $urandom();
        it.offs       = $urandom();
        item_backlog.push_back(it);
    endfunction

    // Mostly entries and queries built from the pools, plus noise
    task automatic queue_random(input int n);
        logic [ID_W-1:0]   qid;
        logic [SLOT_W-1:0] wslot;
        int                lane;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < ((filled_prefix < MAX_ENTRIES_DEF) ? 60 : 45))
            begin
                case ($urandom_range(0, 2))
                    0:       wslot = (filled_prefix < MAX_ENTRIES_DEF)
                                     ? SLOT_W'(filled_prefix) : SLOT_W'($urandom());
                    1:       wslot = SLOT_W'($urandom_range(0, 47));
                    default: wslot = SLOT_W'($urandom());
                endcase
                case ($urandom_range(0, 4))
                    0:
                    begin
                        qid = $urandom();
                    end
                    1:
                    begin
                        qid = id_pool[$urandom_range(0, ID_POOL_N - 1)];
                        lane = $urandom_range(0, ID_BYTES - 1);
                        qid[8*lane +: 8] = 8'($urandom());
                    end
                    default:
                    begin
                        qid = id_pool[$urandom_range(0, ID_POOL_N - 1)];
                    end
                endcase
                put_entry(wslot, qid, pool_name(), pick_version(),
                          $urandom_range(0, 3) == 0, $urandom_range(0, 4) < 2,
                          $urandom(), $urandom());
            end
            else
            begin
                case ($urandom_range(0, 6))
                    0:
                    begin
                        qid = '0;
                    end
                    1:
                    begin
                        qid = $urandom();
                    end
                    default:
                    begin
                        qid = id_pool[$urandom_range(0, ID_POOL_N - 1)];
                        for (int b = 0; b < ID_BYTES; b++)
                        begin
                            if ($urandom_range(0, 1) == 1)
                            begin
                                qid[8*b +: 8] = 8'h00;
                            end
                        end
                    end
                endcase
                put_query(qid, pool_name(), $urandom_range(0, 99) < 85,
                          ($urandom_range(0, 4) == 0)
                          ? MODE_W'($urandom_range(0, MODE_UNUSED))
                          : MODE_W'($urandom_range(0, MODE_LIVE)),
                          pick_version());
            end
        end
    endtask

    // Hold until every item is taken and every result has come back
    task automatic drain();
        do
        begin
            @(negedge clk);
        end
        while (item_backlog.size() != 0 || in_valid || pending_matches.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_count(input logic [COUNT_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        scan_count = v;
        @(negedge clk);
    endtask

    function automatic void note_mismatch(input string what, input match_t exp_r,
                                          input match_t got_r);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t %s: expected found=%0b slot=%0d size=%h offset=%h, got found=%0b slot=%0d size=%h offset=%h",
                     $time, what, exp_r.found, exp_r.slot, exp_r.size, exp_r.offs,
                     got_r.found, got_r.slot, got_r.size, got_r.offs);
        end
    endfunction

    // Update the model on each accepted item and present the next one
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (drive_item.kind == KIND_WRITE)
                begin
                    index_id[drive_item.slot]   = drive_item.id;
                    index_name[drive_item.slot] = drive_item.name;
                    index_ver[drive_item.slot]  = drive_item.ver;
                    index_flags[drive_item.slot][FLAG_DEL_BIT] = drive_item.del;
                    index_flags[drive_item.slot][FLAG_SUP_BIT] = drive_item.sup;
                    index_size[drive_item.slot] = drive_item.size;
                    index_offs[drive_item.slot] = drive_item.offs;
                end
                else
                begin
                    pending_matches.push_back(search_index(drive_item));
                end
            end
            if (!in_valid || in_ready)
            begin
                if (item_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_item = item_backlog.pop_front();
                    drive_item <= next_item;
                    in_valid   <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Check each result against the oldest query and stall at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                seen = {found, match_slot, match_size, match_offset};
                if (pending_matches.size() == 0)
                begin
                    note_mismatch("result with no query outstanding", '0, seen);
                end
                else
                begin
                    want = pending_matches.pop_front();
                    if (seen !== want)
                    begin
                        note_mismatch("result mismatch", want, seen);
                    end
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        #8_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int                 len;
        int                 cut;
        logic [COUNT_W-1:0] next_count;

        // Build the name and id pools; odd names are prefixes of the one before
        for (int p = 0; p < NAME_POOL_N; p++)
        begin
            name_pool[p] = '0;
            len = $urandom_range(0, NAME_CHARS_DEF);
            for (int k = 0; k < len; k++)
            begin
                case ($urandom_range(0, 9))
                    0:       name_pool[p][8*k +: 8] = 8'($urandom_range(1, 255));
                    1:       name_pool[p][8*k +: 8] = ($urandom_range(0, 1) ? 8'h40 : 8'h5b)
                                                      | ($urandom_range(0, 1) ? 8'h20 : 8'h00);
                    default: name_pool[p][8*k +: 8] = 8'(8'h41 + $urandom_range(0, 25))
                                                      | ($urandom_range(0, 1) ? 8'h20 : 8'h00);
                endcase
            end
            if (p % 2 == 1)
            begin
                cut = $urandom_range(0, NAME_CHARS_DEF - 1);
                name_pool[p] = name_pool[p - 1] & ~({NAME_W{1'b1}} << (8 * cut));
            end
        end
        for (int i = 0; i < ID_POOL_N; i++)
        begin
            id_pool[i] = $urandom();
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Count is zero after reset: a query scans nothing
        put_query(32'h0, pack_name("alpha"), 1'b1, MODE_LIVE, '0);
        drain();

        // Directed table: one entry per flag and name corner
        put_entry(8'd0, 32'h1122_3344, pack_name("ALPHA"), 15'd5, 1'b1, 1'b0,
                  $urandom(), $urandom());
        put_entry(8'd1, 32'h1122_3344, pack_name("alpha"), 15'd5, 1'b0, 1'b1,
                  $urandom(), $urandom());
        put_entry(8'd2, 32'h1122_3344, pack_name("aLpHa"), 15'd6, 1'b0, 1'b0,
                  $urandom(), $urandom());
        put_entry(8'd3, 32'hffff_ffff, pack_name("ZZZZZZZZ"), '1, 1'b0, 1'b0, '1, '1);
        put_entry(8'd4, 32'h0, '0, '0, 1'b0, 1'b0, '0, '0);
        put_entry(8'd5, 32'h8000_0001, pack_name("ab") | 64'h0000_007f_7f00_0000, '0,
                  1'b0, 1'b0, $urandom(), $urandom());
        put_entry(8'd6, 32'h00a0_0b00, pack_name("@["), 15'd2, 1'b0, 1'b0,
                  $urandom(), $urandom());
        put_entry(8'd7, 32'h5a5a_5a5a, 64'h0000_0000_00c1_c1c1, 15'd9, 1'b1, 1'b1,
                  $urandom(), $urandom());
        drain();
        write_count(9'd8);

        // Every mode, case folding, wildcards, junk after the terminator
        put_query(32'h0, pack_name("Alpha"), 1'b1, MODE_EXACT, 15'd5);
        put_query(32'h0, pack_name("ALPHA"), 1'b1, MODE_LATEST, '0);
        put_query(32'h0, pack_name("alpha"), 1'b1, MODE_OLD, '0);
        put_query(32'h0, pack_name("alpha"), 1'b1, MODE_DELETED, '0);
        put_query(32'h0000_0001, '1, 1'b0, MODE_LIVE, '0);
        put_query(32'hffff_ffff, pack_name("zzzzzzzz"), 1'b1, MODE_UNUSED, '0);
        put_query(32'h0, '0, 1'b1, MODE_EXACT, '0);
        put_query(32'h0, pack_name("AB") | 64'h0055_5500_0000_0000, 1'b1, MODE_EXACT, '0);
        put_query(32'h0, pack_name("`{"), 1'b1, MODE_LIVE, '0);
        put_query(32'h0, 64'h0000_0000_00c1_c1c1, 1'b1, MODE_DELETED, '0);
        put_query(32'h0022_0000, '0, 1'b0, MODE_LATEST, '0);
        put_query(32'h5500_0000, '0, 1'b0, MODE_LIVE, '0);
        drain();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 77;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 77;
                end
                default:
                begin
                    send_idle_pct  = 23;
                    recv_stall_pct = 23;
                end
            endcase

            // Fill every unwritten slot so the full-depth counts are legal
            if (phase == 6)
            begin
                for (int s = 0; s < MAX_ENTRIES_DEF; s++)
                begin
                    if (!slot_filled[s])
                    begin
                        put_entry(SLOT_W'(s), $urandom(), pool_name(), pick_version(),
                                  $urandom_range(0, 3) == 0, $urandom_range(0, 1) == 1,
                                  $urandom(), $urandom());
                    end
                end
                drain();
            end

            // Never scan past the written prefix of the table
            if (phase == 0)
            begin
                next_count = '0;
            end
            else if (filled_prefix == MAX_ENTRIES_DEF && phase % 3 == 2)
            begin
                case (phase)
                    8:       next_count = '1;
                    11:      next_count = COUNT_W'(MAX_ENTRIES_DEF);
                    default: next_count = COUNT_W'($urandom_range(MAX_ENTRIES_DEF + 1,
                                                                  (1 << COUNT_W) - 2));
                endcase
            end
            else
            begin
                next_count = COUNT_W'($urandom_range(1,
                                      (filled_prefix < 40) ? filled_prefix : 40));
            end
            write_count(next_count);

            // Pause the sender mid phase until all results are back
            queue_random(HALF_PHASE);
            drain();
            queue_random(HALF_PHASE);
            drain();
        end

        repeat (SCAN_TAIL) @(posedge clk);
        if (mismatch_count == 0 && pending_matches.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
